>>> hw/rtl/tqv_pkg.sv
package tqv_pkg;

   // Defaults for the top level parameters
   localparam int unsigned DEF_MAX_COUNT       = 256;
   localparam int unsigned DEF_SINE_TABLE_BITS = 10;

   // Field widths
   localparam int unsigned IDX_W      = 8;   // request index
   localparam int unsigned IDXP_W     = 9;   // index plus one
   localparam int unsigned CNT_W      = 9;   // ring / side count
   localparam int unsigned RAD_W      = 16;  // radii, Q8.8
   localparam int unsigned TRIG_W     = 16;  // sine / cosine, Q1.14
   localparam int unsigned TEX_W      = 17;  // texture, Q0.16 with 1.0
   localparam int unsigned POS_W      = 18;  // position, Q9.8 signed
   localparam int unsigned CSR_IDX_W  = 4;
   localparam int unsigned CSR_DATA_W = 16;

   // Quotient of index * 2^17 / count; tex and phase both derive from it
   localparam int unsigned TEX_SHIFT = 17;
   localparam int unsigned DIV_K     = TEX_SHIFT + IDXP_W + CNT_W;
   localparam int unsigned RECIP_W   = DIV_K + 1;
   localparam int unsigned PROD_W    = IDXP_W + RECIP_W;
   localparam int unsigned QUO_SH    = DIV_K - TEX_SHIFT;
   localparam int unsigned QUO_W     = PROD_W - QUO_SH;
   localparam int unsigned TEX_ONE   = 65536;
   localparam int unsigned RND_SH    = 14;

   // Item queue between front and back
   localparam int unsigned Q_DEPTH = 2;

   // Slots of an entry: ring i, ring i+1, side j, side j+1
   localparam int unsigned SEL_RING_LO = 0;
   localparam int unsigned SEL_RING_HI = 1;
   localparam int unsigned SEL_SIDE_LO = 2;
   localparam int unsigned SEL_SIDE_HI = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_INNER_RADIUS = 4'd0,
      CSR_OUTER_RADIUS = 4'd1,
      CSR_RING_COUNT   = 4'd2,
      CSR_SIDE_COUNT   = 4'd3
   } csr_reg_type;

   typedef struct packed {
      logic [CNT_W-1:0] ring_count;
      logic [CNT_W-1:0] side_count;
      logic [CNT_W-1:0] ring_eff;
      logic [CNT_W-1:0] side_eff;
   } tqv_cfg_type;

   typedef struct packed {
      logic               busy;
      logic [RECIP_W-1:0] ring_m;
      logic [RECIP_W-1:0] side_m;
   } tqv_recip_type;

   typedef struct packed {
      logic [3:0][TRIG_W-1:0] sin_v;
      logic [3:0][TRIG_W-1:0] cos_v;
      logic [3:0][TEX_W-1:0]  tex_v;
      logic                   err;
   } tqv_entry_type;

   // sin(pi/2 * r / 2^qbits) in Q1.14, odd polynomial in Q30
   function automatic logic [14:0] quarter_sine_fn(input int unsigned r,
                                                   input int unsigned qbits);
      longint unsigned q;
      longint unsigned q2;
      longint unsigned s;
      longint unsigned res;
      begin
         q   = longint'(r) << (30 - qbits);
         q2  = (q * q) >> 30;
         s   = 64'd172272;
         s   = 64'd5026995 - ((q2 * s) >> 30);
         s   = 64'd85569306 - ((q2 * s) >> 30);
         s   = 64'd693598668 - ((q2 * s) >> 30);
         s   = 64'd1686629713 - ((q2 * s) >> 30);
         res = (q * s) >> 30;
         res = (res + 64'd32768) >> 16;
         if (res > 64'd16384) begin
            res = 64'd16384;
         end
         return res[14:0];
      end
   endfunction

endpackage

>>> hw/rtl/torus_quad_vertex_generator.sv
// Channel   Direction  Handshake              Payload
// req_      in         start / busy           ring_index, side_index
// rsp_      out        rsp_strobe, no stall   slot, last, position, normal, tex, error
// csr_      in         csr_valid / csr_ready  csr_index, csr_data
//
// Each item yields four vertices on consecutive cycles; a new item can be taken once the
// last index of the current one issues, set by the front's one reciprocal multiplier (one
// index a cycle, four indices an item) and by the back emitting one vertex a cycle.
// After reset and after each count write, busy stays high while the bit-serial divider
// forms the count's reciprocal.
// The receiver cannot stall; busy also rises when the two-entry item queue is committed.
module torus_quad_vertex_generator #(
   parameter int unsigned MAX_COUNT       = tqv_pkg::DEF_MAX_COUNT,
   parameter int unsigned SINE_TABLE_BITS = tqv_pkg::DEF_SINE_TABLE_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [tqv_pkg::IDX_W-1:0]         req_ring_index,
   input  logic [tqv_pkg::IDX_W-1:0]         req_side_index,
   output logic                              rsp_strobe,
   output logic [1:0]                        rsp_vertex_slot,
   output logic                              rsp_last_vertex,
   output logic signed [tqv_pkg::POS_W-1:0]  rsp_pos_x,
   output logic signed [tqv_pkg::POS_W-1:0]  rsp_pos_y,
   output logic signed [tqv_pkg::POS_W-1:0]  rsp_pos_z,
   output logic signed [tqv_pkg::TRIG_W-1:0] rsp_norm_x,
   output logic signed [tqv_pkg::TRIG_W-1:0] rsp_norm_y,
   output logic signed [tqv_pkg::TRIG_W-1:0] rsp_norm_z,
   output logic [tqv_pkg::TEX_W-1:0]         rsp_tex_u,
   output logic [tqv_pkg::TEX_W-1:0]         rsp_tex_v,
   output logic                              rsp_range_error,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [tqv_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [tqv_pkg::CSR_DATA_W-1:0]    csr_data
);
   import tqv_pkg::*;

   logic [RAD_W-1:0] inner_ff;
   logic [RAD_W-1:0] outer_ff;
   logic [CNT_W-1:0] ring_ff;
   logic [CNT_W-1:0] side_ff;
   logic             load_ring_ff;
   logic             load_side_ff;

   tqv_cfg_type   cfg;
   tqv_recip_type recip;
   tqv_entry_type push_entry;
   tqv_entry_type head;

   logic               ring_busy;
   logic               side_busy;
   logic [RECIP_W-1:0] ring_m;
   logic [RECIP_W-1:0] side_m;
   logic               push;
   logic               pop;
   logic               q_valid;

   assign csr_ready = 1'b1;

   // Register writes; a count write restarts its reciprocal
   always_ff @(posedge clock) begin
      if (reset) begin
         inner_ff     <= RAD_W'(256);
         outer_ff     <= RAD_W'(512);
         ring_ff      <= CNT_W'(32);
         side_ff      <= CNT_W'(16);
         load_ring_ff <= 1'b1;
         load_side_ff <= 1'b1;
      end else begin
         load_ring_ff <= 1'b0;
         load_side_ff <= 1'b0;
         if (csr_valid) begin
            case (csr_reg_type'(csr_index))
               CSR_INNER_RADIUS: begin
                  inner_ff <= csr_data;
               end
               CSR_OUTER_RADIUS: begin
                  outer_ff <= csr_data;
               end
               CSR_RING_COUNT: begin
                  ring_ff      <= csr_data[CNT_W-1:0];
                  load_ring_ff <= 1'b1;
               end
               CSR_SIDE_COUNT: begin
                  side_ff      <= csr_data[CNT_W-1:0];
                  load_side_ff <= 1'b1;
               end
               default: begin
               end
            endcase
         end
      end
   end

   // Effective counts: zero reads as one, large values clip
   function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] c);
      if (c == '0) begin
         return CNT_W'(1);
      end else if (32'(c) > MAX_COUNT) begin
         return CNT_W'(MAX_COUNT);
      end
      return c;
   endfunction

   always_comb begin
      cfg.ring_count = ring_ff;
      cfg.side_count = side_ff;
      cfg.ring_eff   = eff_count(ring_ff);
      cfg.side_eff   = eff_count(side_ff);
   end

   tqv_recip u_recip_ring (
      .clock (clock),
      .reset (reset),
      .load  (load_ring_ff),
      .count (cfg.ring_eff),
      .recip (ring_m),
      .busy  (ring_busy)
   );

   tqv_recip u_recip_side (
      .clock (clock),
      .reset (reset),
      .load  (load_side_ff),
      .count (cfg.side_eff),
      .recip (side_m),
      .busy  (side_busy)
   );

   always_comb begin
      recip.busy   = ring_busy || side_busy || load_ring_ff || load_side_ff;
      recip.ring_m = ring_m;
      recip.side_m = side_m;
   end

   tqv_front #(
      .SINE_TABLE_BITS (SINE_TABLE_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .ring_index (req_ring_index),
      .side_index (req_side_index),
      .cfg        (cfg),
      .recip      (recip),
      .pop        (pop),
      .push       (push),
      .push_entry (push_entry)
   );

   tqv_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .not_empty  (q_valid),
      .head       (head)
   );

   tqv_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .q_entry      (head),
      .pop          (pop),
      .inner_radius (inner_ff),
      .outer_radius (outer_ff),
      .strobe       (rsp_strobe),
      .vertex_slot  (rsp_vertex_slot),
      .last_vertex  (rsp_last_vertex),
      .pos_x        (rsp_pos_x),
      .pos_y        (rsp_pos_y),
      .pos_z        (rsp_pos_z),
      .norm_x       (rsp_norm_x),
      .norm_y       (rsp_norm_y),
      .norm_z       (rsp_norm_z),
      .tex_u        (rsp_tex_u),
      .tex_v        (rsp_tex_v),
      .range_error  (rsp_range_error)
   );

endmodule

>>> hw/rtl/tqv_recip.sv
module tqv_recip (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        load,
   input  logic [tqv_pkg::CNT_W-1:0]   count,
   output logic [tqv_pkg::RECIP_W-1:0] recip,
   output logic                        busy
);
   import tqv_pkg::*;

   localparam int unsigned CNT_BITS = $clog2(RECIP_W + 1);

   logic [RECIP_W-1:0]  num_ff;
   logic [CNT_W-1:0]    rem_ff;
   logic [CNT_BITS-1:0] iter_ff;
   logic                busy_ff;
   logic [CNT_W:0]      rem_wide;
   logic [CNT_W:0]      rem_sub;
   logic                fits;

   // One quotient bit a cycle: ceil(2^K / count)
   always_comb begin
      rem_wide = {rem_ff, num_ff[RECIP_W-1]};
      fits     = rem_wide >= {1'b0, count};
      rem_sub  = rem_wide - {1'b0, count};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         iter_ff <= '0;
      end else if (load) begin
         num_ff  <= (RECIP_W'(1) << DIV_K) + RECIP_W'(count) - RECIP_W'(1);
         rem_ff  <= '0;
         iter_ff <= CNT_BITS'(RECIP_W);
         busy_ff <= 1'b1;
      end else if (busy_ff) begin
         num_ff  <= {num_ff[RECIP_W-2:0], fits};
         rem_ff  <= fits ? rem_sub[CNT_W-1:0] : rem_wide[CNT_W-1:0];
         iter_ff <= iter_ff - CNT_BITS'(1);
         if (iter_ff == CNT_BITS'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   assign recip = num_ff;
   assign busy  = busy_ff;

endmodule

>>> hw/rtl/tqv_front.sv
module tqv_front #(
   parameter int unsigned SINE_TABLE_BITS = tqv_pkg::DEF_SINE_TABLE_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [tqv_pkg::IDX_W-1:0] ring_index,
   input  logic [tqv_pkg::IDX_W-1:0] side_index,
   input  tqv_pkg::tqv_cfg_type      cfg,
   input  tqv_pkg::tqv_recip_type    recip,
   input  logic                      pop,
   output logic                      push,
   output tqv_pkg::tqv_entry_type    push_entry
);
   import tqv_pkg::*;

   localparam int unsigned PH_W   = SINE_TABLE_BITS;
   localparam int unsigned QN     = 1 << (PH_W - 2);
   localparam int unsigned ADDR_W = PH_W - 1;
   localparam int unsigned F_HI   = TEX_SHIFT - 1;
   localparam int unsigned F_LO   = TEX_SHIFT - 1 - PH_W;
   localparam int unsigned CRD_W  = $clog2(Q_DEPTH + 1);

   logic [14:0] rom [0:QN];

   logic             active_ff;
   logic [1:0]       step_ff;
   logic [IDX_W-1:0] ri_ff;
   logic [IDX_W-1:0] si_ff;
   logic             err_ff;
   logic [CRD_W-1:0] credit_ff;
   logic [CRD_W-1:0] credit_in;

   logic              s1_valid_ff;
   logic [1:0]        s1_step_ff;
   logic              s1_err_ff;
   logic [PROD_W-1:0] s1_prod_ff;

   tqv_entry_type asm_ff;
   logic          push_ff;

   logic               accept;
   logic               err_in;
   logic [IDXP_W-1:0]  idx;
   logic [RECIP_W-1:0] m_sel;
   logic [QUO_W-1:0]   quo;
   logic [QUO_W-1:0]   quo_p1;
   logic [QUO_W-1:0]   tex_raw;
   logic [TEX_W-1:0]   tex;
   logic [PH_W:0]      f_p1;
   logic [PH_W-1:0]    phase;
   logic [PH_W-1:0]    ph [2];
   logic [ADDR_W-1:0]  addr [2];
   logic [TRIG_W-1:0]  trig [2];

   // Quarter-wave sine table
   for (genvar g = 0; g <= QN; g++) begin : g_rom
      assign rom[g] = quarter_sine_fn(g, PH_W - 2);
   end

   // Accept while the last index of the current item issues
   assign busy   = recip.busy || (credit_ff == '0) || (active_ff && step_ff != 2'd3);
   assign accept = start && !busy;
   assign err_in = (cfg.ring_count == '0) || (cfg.side_count == '0) ||
                   ({1'b0, ring_index} >= cfg.ring_eff) ||
                   ({1'b0, side_index} >= cfg.side_eff);

   // Credits cover queue slots and items still in the pipe
   always_comb begin
      credit_in = credit_ff;
      if (accept) begin
         credit_in = credit_in - CRD_W'(1);
      end
      if (pop) begin
         credit_in = credit_in + CRD_W'(1);
      end
   end

   // Walk the four indices of the held item
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         step_ff   <= '0;
         credit_ff <= CRD_W'(Q_DEPTH);
      end else begin
         credit_ff <= credit_in;
         if (accept) begin
            active_ff <= 1'b1;
            step_ff   <= '0;
            ri_ff     <= ring_index;
            si_ff     <= side_index;
            err_ff    <= err_in;
         end else if (active_ff) begin
            step_ff <= step_ff + 2'd1;
            if (step_ff == 2'd3) begin
               active_ff <= 1'b0;
            end
         end
      end
   end

   // Index times reciprocal
   always_comb begin
      idx   = {1'b0, (step_ff[1] ? si_ff : ri_ff)} + IDXP_W'(step_ff[0]);
      m_sel = step_ff[1] ? recip.side_m : recip.ring_m;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= active_ff;
      end
      s1_step_ff <= step_ff;
      s1_err_ff  <= err_ff;
      s1_prod_ff <= PROD_W'(idx) * PROD_W'(m_sel);
   end

   // Texture coordinate and phase from the quotient
   always_comb begin
      quo     = s1_prod_ff[PROD_W-1:QUO_SH];
      quo_p1  = quo + QUO_W'(1);
      tex_raw = quo_p1 >> 1;
      tex     = (tex_raw > QUO_W'(TEX_ONE)) ? TEX_W'(TEX_ONE) : tex_raw[TEX_W-1:0];
      f_p1    = quo[F_HI:F_LO] + (PH_W + 1)'(1);
      phase   = f_p1[PH_W:1];
   end

   // Sine and cosine by quarter-wave symmetry
   always_comb begin
      for (int k = 0; k < 2; k++) begin
         ph[k]   = phase + (PH_W'(k) << (PH_W - 2));
         addr[k] = ph[k][PH_W-2] ? (ADDR_W'(QN) - ADDR_W'(ph[k][PH_W-3:0]))
                                 : ADDR_W'(ph[k][PH_W-3:0]);
         trig[k] = ph[k][PH_W-1] ? (TRIG_W'(0) - {1'b0, rom[addr[k]]})
                                 : {1'b0, rom[addr[k]]};
      end
   end

   // Gather the four slots, then hand the item on
   always_ff @(posedge clock) begin
      if (reset) begin
         push_ff <= 1'b0;
      end else begin
         push_ff <= s1_valid_ff && (s1_step_ff == 2'd3);
      end
      if (s1_valid_ff) begin
         asm_ff.sin_v[s1_step_ff] <= trig[0];
         asm_ff.cos_v[s1_step_ff] <= trig[1];
         asm_ff.tex_v[s1_step_ff] <= tex;
         asm_ff.err               <= s1_err_ff;
      end
   end

   assign push       = push_ff;
   assign push_entry = asm_ff;

endmodule

>>> hw/rtl/tqv_queue.sv
module tqv_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  tqv_pkg::tqv_entry_type push_entry,
   input  logic                   pop,
   output logic                   not_empty,
   output tqv_pkg::tqv_entry_type head
);
   import tqv_pkg::*;

   localparam int unsigned PTR_W = $clog2(Q_DEPTH);
   localparam int unsigned CNT_W_Q = $clog2(Q_DEPTH + 1);

   tqv_entry_type       mem_ff [Q_DEPTH];
   logic [PTR_W-1:0]    wr_ff;
   logic [PTR_W-1:0]    rd_ff;
   logic [CNT_W_Q-1:0]  fill_ff;

   // Ring buffer; the front's credits keep it from overflowing
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= '0;
         rd_ff   <= '0;
         fill_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= (wr_ff == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ff <= (rd_ff == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
         end
         fill_ff <= fill_ff + CNT_W_Q'(push) - CNT_W_Q'(pop);
      end
      if (push) begin
         mem_ff[wr_ff] <= push_entry;
      end
   end

   assign not_empty = fill_ff != '0;
   assign head      = mem_ff[rd_ff];

endmodule

>>> hw/rtl/tqv_back.sv
module tqv_back (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             q_valid,
   input  tqv_pkg::tqv_entry_type           q_entry,
   output logic                             pop,
   input  logic [tqv_pkg::RAD_W-1:0]        inner_radius,
   input  logic [tqv_pkg::RAD_W-1:0]        outer_radius,
   output logic                             strobe,
   output logic [1:0]                       vertex_slot,
   output logic                             last_vertex,
   output logic signed [tqv_pkg::POS_W-1:0] pos_x,
   output logic signed [tqv_pkg::POS_W-1:0] pos_y,
   output logic signed [tqv_pkg::POS_W-1:0] pos_z,
   output logic signed [tqv_pkg::TRIG_W-1:0] norm_x,
   output logic signed [tqv_pkg::TRIG_W-1:0] norm_y,
   output logic signed [tqv_pkg::TRIG_W-1:0] norm_z,
   output logic [tqv_pkg::TEX_W-1:0]        tex_u,
   output logic [tqv_pkg::TEX_W-1:0]        tex_v,
   output logic                             range_error
);
   import tqv_pkg::*;

   localparam int unsigned RP_W = RAD_W + TRIG_W + 1;   // radius times trig
   localparam int unsigned NP_W = 2 * TRIG_W;           // trig times trig
   localparam int unsigned D_W  = 19;                   // R + r*cos p
   localparam int unsigned DP_W = TRIG_W + D_W;         // trig times d
   localparam int          HALF = 1 << (RND_SH - 1);

   tqv_entry_type ent_ff;
   logic          act_ff;
   logic [1:0]    slot_ff;

   logic [1:0] ring_sel;
   logic [1:0] u_sel;
   logic [1:0] side_sel;

   logic signed [TRIG_W-1:0] sin_t;
   logic signed [TRIG_W-1:0] cos_t;
   logic signed [TRIG_W-1:0] sin_p;
   logic signed [TRIG_W-1:0] cos_p;

   // stage one
   logic                     p1_valid_ff;
   logic [1:0]               p1_slot_ff;
   logic                     p1_err_ff;
   logic [TEX_W-1:0]         p1_u_ff;
   logic [TEX_W-1:0]         p1_v_ff;
   logic signed [TRIG_W-1:0] p1_sin_t_ff;
   logic signed [TRIG_W-1:0] p1_cos_t_ff;
   logic signed [TRIG_W-1:0] p1_sin_p_ff;
   logic signed [RP_W-1:0]   p1_rc_ff;
   logic signed [RP_W-1:0]   p1_rs_ff;
   logic signed [NP_W-1:0]   p1_nx_ff;
   logic signed [NP_W-1:0]   p1_ny_ff;

   // stage two
   logic                     p2_valid_ff;
   logic [1:0]               p2_slot_ff;
   logic                     p2_err_ff;
   logic [TEX_W-1:0]         p2_u_ff;
   logic [TEX_W-1:0]         p2_v_ff;
   logic signed [TRIG_W-1:0] p2_sin_t_ff;
   logic signed [TRIG_W-1:0] p2_cos_t_ff;
   logic signed [D_W-1:0]    p2_d_ff;
   logic signed [POS_W-1:0]  p2_pz_ff;
   logic signed [TRIG_W-1:0] p2_nx_ff;
   logic signed [TRIG_W-1:0] p2_ny_ff;
   logic signed [TRIG_W-1:0] p2_nz_ff;

   // output stage
   logic                     out_valid_ff;
   logic [1:0]               out_slot_ff;
   logic                     out_err_ff;
   logic [TEX_W-1:0]         out_u_ff;
   logic [TEX_W-1:0]         out_v_ff;
   logic signed [POS_W-1:0]  out_px_ff;
   logic signed [POS_W-1:0]  out_py_ff;
   logic signed [POS_W-1:0]  out_pz_ff;
   logic signed [TRIG_W-1:0] out_nx_ff;
   logic signed [TRIG_W-1:0] out_ny_ff;
   logic signed [TRIG_W-1:0] out_nz_ff;

   logic signed [RP_W-1:0] rc_rnd;
   logic signed [RP_W-1:0] rs_rnd;
   logic signed [NP_W-1:0] nx_rnd;
   logic signed [NP_W-1:0] ny_rnd;
   logic signed [D_W:0]    d_sum;
   logic signed [DP_W-1:0] px_prod;
   logic signed [DP_W-1:0] py_prod;
   logic signed [DP_W-1:0] px_rnd;
   logic signed [DP_W-1:0] py_rnd;

   // Take the next item as the current one issues its last corner
   assign pop = q_valid && (!act_ff || slot_ff == 2'd3);

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff  <= 1'b0;
         slot_ff <= '0;
      end else if (pop) begin
         act_ff  <= 1'b1;
         slot_ff <= '0;
      end else if (act_ff) begin
         slot_ff <= slot_ff + 2'd1;
         if (slot_ff == 2'd3) begin
            act_ff <= 1'b0;
         end
      end
      if (pop) begin
         ent_ff <= q_entry;
      end
   end

   // Corner order: (i+1,j) (i,j) (i,j+1) (i+1,j+1); u crosswise to the ring
   always_comb begin
      ring_sel = (slot_ff == 2'd0 || slot_ff == 2'd3) ? 2'(SEL_RING_HI) : 2'(SEL_RING_LO);
      u_sel    = (slot_ff == 2'd0 || slot_ff == 2'd3) ? 2'(SEL_RING_LO) : 2'(SEL_RING_HI);
      side_sel = slot_ff[1] ? 2'(SEL_SIDE_HI) : 2'(SEL_SIDE_LO);
      sin_t    = $signed(ent_ff.sin_v[ring_sel]);
      cos_t    = $signed(ent_ff.cos_v[ring_sel]);
      sin_p    = $signed(ent_ff.sin_v[side_sel]);
      cos_p    = $signed(ent_ff.cos_v[side_sel]);
   end

   // Stage one: radius and normal products
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff <= act_ff;
      end
      p1_slot_ff  <= slot_ff;
      p1_err_ff   <= ent_ff.err;
      p1_u_ff     <= ent_ff.tex_v[u_sel];
      p1_v_ff     <= ent_ff.tex_v[side_sel];
      p1_sin_t_ff <= sin_t;
      p1_cos_t_ff <= cos_t;
      p1_sin_p_ff <= sin_p;
      p1_rc_ff    <= $signed({1'b0, inner_radius}) * RP_W'(cos_p);
      p1_rs_ff    <= $signed({1'b0, inner_radius}) * RP_W'(sin_p);
      p1_nx_ff    <= NP_W'(cos_t) * NP_W'(cos_p);
      p1_ny_ff    <= -(NP_W'(sin_t) * NP_W'(cos_p));
   end

   // Stage two: round, and form the distance from the axis
   always_comb begin
      rc_rnd = (p1_rc_ff + RP_W'(HALF)) >>> RND_SH;
      rs_rnd = (p1_rs_ff + RP_W'(HALF)) >>> RND_SH;
      nx_rnd = (p1_nx_ff + NP_W'(HALF)) >>> RND_SH;
      ny_rnd = (p1_ny_ff + NP_W'(HALF)) >>> RND_SH;
      d_sum  = $signed({{(D_W + 1 - RAD_W){1'b0}}, outer_radius}) + rc_rnd[D_W:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_valid_ff <= 1'b0;
      end else begin
         p2_valid_ff <= p1_valid_ff;
      end
      p2_slot_ff  <= p1_slot_ff;
      p2_err_ff   <= p1_err_ff;
      p2_u_ff     <= p1_u_ff;
      p2_v_ff     <= p1_v_ff;
      p2_sin_t_ff <= p1_sin_t_ff;
      p2_cos_t_ff <= p1_cos_t_ff;
      p2_d_ff     <= d_sum[D_W-1:0];
      p2_pz_ff    <= rs_rnd[POS_W-1:0];
      p2_nx_ff    <= nx_rnd[TRIG_W-1:0];
      p2_ny_ff    <= ny_rnd[TRIG_W-1:0];
      p2_nz_ff    <= p1_sin_p_ff;
   end

   // Stage three: position x and y
   always_comb begin
      px_prod = DP_W'(p2_cos_t_ff) * DP_W'(p2_d_ff);
      py_prod = -(DP_W'(p2_sin_t_ff) * DP_W'(p2_d_ff));
      px_rnd  = (px_prod + DP_W'(HALF)) >>> RND_SH;
      py_rnd  = (py_prod + DP_W'(HALF)) >>> RND_SH;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= p2_valid_ff;
      end
      out_slot_ff <= p2_slot_ff;
      out_err_ff  <= p2_err_ff;
      out_u_ff    <= p2_u_ff;
      out_v_ff    <= p2_v_ff;
      out_px_ff   <= px_rnd[POS_W-1:0];
      out_py_ff   <= py_rnd[POS_W-1:0];
      out_pz_ff   <= p2_pz_ff;
      out_nx_ff   <= p2_nx_ff;
      out_ny_ff   <= p2_ny_ff;
      out_nz_ff   <= p2_nz_ff;
   end

   assign strobe      = out_valid_ff;
   assign vertex_slot = out_slot_ff;
   assign last_vertex = out_slot_ff == 2'd3;
   assign pos_x       = out_px_ff;
   assign pos_y       = out_py_ff;
   assign pos_z       = out_pz_ff;
   assign norm_x      = out_nx_ff;
   assign norm_y      = out_ny_ff;
   assign norm_z      = out_nz_ff;
   assign tex_u       = out_u_ff;
   assign tex_v       = out_v_ff;
   assign range_error = out_err_ff;

endmodule

>>> hw/rtl/tqv_checker.sv
module tqv_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      busy,
   input logic                      rsp_strobe,
   input logic [1:0]                rsp_vertex_slot,
   input logic                      rsp_last_vertex,
   input logic [tqv_pkg::TEX_W-1:0] rsp_tex_u,
   input logic [tqv_pkg::TEX_W-1:0] rsp_tex_v,
   input logic                      rsp_range_error
);
   import tqv_pkg::*;

   // Hold off items while the reciprocals are rebuilt after reset
   a_busy_after_reset: assert property (@(posedge clock) reset |=> busy)
      else $error("busy low right after reset");

   // Corners of a quad follow one another without a gap
   a_slot_order: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_vertex_slot != 2'd3 |=>
         rsp_strobe && rsp_vertex_slot == $past(rsp_vertex_slot) + 2'd1)
      else $error("vertex slots out of order");

   // Last flag marks the fourth corner only
   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_last_vertex == (rsp_vertex_slot == 2'd3))
      else $error("last_vertex disagrees with slot");

   // Error flag is the same on all corners of a quad
   a_err_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_vertex_slot != 2'd0 |-> $stable(rsp_range_error))
      else $error("range_error changed within a quad");

   // Texture coordinates saturate at one
   a_tex_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_tex_u <= TEX_W'(TEX_ONE) && rsp_tex_v <= TEX_W'(TEX_ONE))
      else $error("texture coordinate above one");

endmodule

bind torus_quad_vertex_generator tqv_checker u_tqv_checker (.*);
